### rtl/core/lesq_pkg.sv
`timescale 1ns / 1ps

package lesq_pkg;

  // payload and register widths
  localparam int CHAR_W      = 8;
  localparam int SCORE_W     = 11;
  localparam int ROW_WIDTH_W = 11;
  localparam int TOP_W       = 10;
  localparam int LEFT_W      = 10;
  localparam int CFG_DATA_W  = 11;

  typedef logic [SCORE_W-1:0] score_t;
  typedef logic [CHAR_W-1:0]  char_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_ROW_WIDTH     = 1'b0,
    REG_OBSTACLE_CHAR = 1'b1
  } cfg_idx_t;

  // least of three scores
  function automatic score_t least3(input score_t p, input score_t q, input score_t r);
    score_t m;
    m = (p < q) ? p : q;
    return (m < r) ? m : r;
  endfunction

endpackage

### rtl/core/lesq_line_buf.sv
`timescale 1ns / 1ps

module lesq_line_buf
  import lesq_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  score_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output score_t        rd_data
);

  score_t mem [DEPTH];
  score_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, forwarding a write to the same entry in the same cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/largest_empty_square_scan_core.sv
`timescale 1ns / 1ps
// result path: the last cell's request is held in the input register, its result in the result register
// throughput: 1 cell per cycle from the line buffer's one read and one write per cycle;
// a last cell stalls in the input register while an older result is not taken
// the read of the previous row's score is issued on acceptance, from the column counter
// reset: synchronous active-low; counters, scores and best square clear, row_width goes
// to 1 and obstacle_char to 0; the line buffer is not cleared and needs no clearing pass

module largest_empty_square_scan_core
  import lesq_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration port
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // cell requests
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CHAR_W-1:0]     in_cell_char,
  input  logic                  in_last_cell,
  // result requests
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SCORE_W-1:0]    out_side_len,
  output logic [TOP_W-1:0]      out_square_top,
  output logic [LEFT_W-1:0]     out_square_left
);

  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WCW = (CW + 1 > ROW_WIDTH_W) ? CW + 1 : ROW_WIDTH_W;
  localparam int TCW = ((RW > SCORE_W) ? RW : SCORE_W) + 1;
  localparam int LCW = ((CW > SCORE_W) ? CW : SCORE_W) + 1;

  // configuration registers
  logic [ROW_WIDTH_W-1:0] row_width_r;
  char_t                  obstacle_char_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r     <= ROW_WIDTH_W'(1);
      obstacle_char_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_WIDTH:     row_width_r     <= cfg_wdata[ROW_WIDTH_W-1:0];
        REG_OBSTACLE_CHAR: obstacle_char_r <= cfg_wdata[CHAR_W-1:0];
      endcase
    end
  end

  // handshake control
  logic s1_valid_r, s1_last_r, s1_go, in_acc;
  logic out_valid_r;

  assign s1_go    = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_acc   = in_valid && in_ready;

  // effective row width: zero counts as one, clamp to the line buffer depth
  logic [WCW-1:0] width_ext, eff_width;
  assign width_ext = WCW'(row_width_r);
  assign eff_width = (width_ext == '0) ? WCW'(1) :
                     (width_ext > WCW'(MAX_WIDTH)) ? WCW'(MAX_WIDTH) : width_ext;

  // position of the accepted cell and counter advance
  logic [CW-1:0]  column_count_r, column_count_nxt, cur_col;
  logic [RW-1:0]  row_count_r, row_count_nxt, cur_row;
  logic [WCW-1:0] col_p1;
  logic           row_end;

  always_comb begin
    if (WCW'(column_count_r) >= eff_width) begin
      cur_col = '0;
      cur_row = (row_count_r < RW'(MAX_HEIGHT - 1)) ? row_count_r + RW'(1) : row_count_r;
    end else begin
      cur_col = column_count_r;
      cur_row = row_count_r;
    end
    col_p1  = WCW'(cur_col) + WCW'(1);
    row_end = (col_p1 >= eff_width);
    if (in_last_cell) begin
      column_count_nxt = '0;
      row_count_nxt    = '0;
    end else if (row_end) begin
      column_count_nxt = '0;
      row_count_nxt    = (cur_row < RW'(MAX_HEIGHT - 1)) ? cur_row + RW'(1) : cur_row;
    end else begin
      column_count_nxt = CW'(col_p1);
      row_count_nxt    = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      row_count_r    <= '0;
    end else if (in_acc) begin
      column_count_r <= column_count_nxt;
      row_count_r    <= row_count_nxt;
    end
  end

  // input register stage
  char_t         s1_char_r;
  logic [CW-1:0] s1_col_r;
  logic [RW-1:0] s1_row_r;
  logic          s1_row_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_char_r    <= in_cell_char;
      s1_last_r    <= in_last_cell;
      s1_col_r     <= cur_col;
      s1_row_r     <= cur_row;
      s1_row_end_r <= row_end;
    end
  end

  // previous row scores
  score_t up_score, score;

  lesq_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (s1_go),
    .wr_addr (s1_col_r),
    .wr_data (score),
    .rd_en   (in_acc),
    .rd_addr (cur_col),
    .rd_data (up_score)
  );

  // cell score
  score_t left_score_r, diag_score_r;

  always_comb begin
    if (s1_char_r == obstacle_char_r) begin
      score = '0;
    end else if ((s1_row_r == '0) || (s1_col_r == '0)) begin
      score = SCORE_W'(1);
    end else begin
      score = least3(up_score, left_score_r, diag_score_r) + SCORE_W'(1);
    end
  end

  // best square tracking
  score_t        best_size_r, best_size_nxt;
  logic [RW-1:0] best_top_r, best_top_nxt;
  logic [CW-1:0] best_left_r, best_left_nxt;
  logic [TCW-1:0] row_p1, score_t_ext;
  logic [LCW-1:0] colx_p1, score_l_ext;

  always_comb begin
    row_p1      = TCW'(s1_row_r) + TCW'(1);
    score_t_ext = TCW'(score);
    colx_p1     = LCW'(s1_col_r) + LCW'(1);
    score_l_ext = LCW'(score);
    if (score > best_size_r) begin
      best_size_nxt = score;
      best_top_nxt  = (row_p1 >= score_t_ext) ? RW'(row_p1 - score_t_ext) : '0;
      best_left_nxt = (colx_p1 >= score_l_ext) ? CW'(colx_p1 - score_l_ext) : '0;
    end else begin
      best_size_nxt = best_size_r;
      best_top_nxt  = best_top_r;
      best_left_nxt = best_left_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_score_r <= '0;
      diag_score_r <= '0;
      best_size_r  <= '0;
      best_top_r   <= '0;
      best_left_r  <= '0;
    end else if (s1_go) begin
      if (s1_last_r) begin
        left_score_r <= '0;
        diag_score_r <= '0;
        best_size_r  <= '0;
        best_top_r   <= '0;
        best_left_r  <= '0;
      end else begin
        left_score_r <= s1_row_end_r ? '0 : score;
        diag_score_r <= s1_row_end_r ? '0 : up_score;
        best_size_r  <= best_size_nxt;
        best_top_r   <= best_top_nxt;
        best_left_r  <= best_left_nxt;
      end
    end
  end

  // result register
  score_t            out_size_r;
  logic [TOP_W-1:0]  out_top_r;
  logic [LEFT_W-1:0] out_left_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_size_r <= best_size_nxt;
      out_top_r  <= TOP_W'(best_top_nxt);
      out_left_r <= LEFT_W'(best_left_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_side_len    = out_size_r;
  assign out_square_top  = out_top_r;
  assign out_square_left = out_left_r;

endmodule

### rtl/core/lesq_checker.sv
`timescale 1ns / 1ps

module lesq_checker
  import lesq_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  in_last_cell,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [SCORE_W-1:0]    out_side_len,
  input logic [TOP_W-1:0]      out_square_top,
  input logic [LEFT_W-1:0]     out_square_left
);

  logic last_acc;
  assign last_acc = in_valid && in_ready && in_last_cell;

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_side_len))
    else $error("result request dropped or changed while stalled");

  // the last cell always produces a result
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    last_acc |-> ##2 out_valid)
    else $error("no result after the last cell");

  // a fresh result only follows a last cell
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(last_acc, 2))
    else $error("result without a last cell");

  // an empty result carries a zero position
  a_empty_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_side_len == '0) |-> (out_square_top == '0) && (out_square_left == '0))
    else $error("nonzero position with no square");

endmodule

bind largest_empty_square_scan_core lesq_checker u_lesq_checker (.*);

### tb/tb_largest_empty_square_scan_core.sv
`timescale 1ns / 1ps

module tb_largest_empty_square_scan_core;
  import lesq_pkg::*;

  localparam int MAX_W      = 1024;
  localparam int MAX_H      = 1024;
  localparam int DRAIN_PAD  = 6;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [SCORE_W-1:0] side;
    logic [TOP_W-1:0]   top_row;
    logic [LEFT_W-1:0]  left_col;
  } square_t;

  typedef struct packed {
    bit      pin;
    square_t sq;
  } pinned_sq_t;

  typedef enum bit {ROW_CELL, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    cfg_idx_t              idx;
    logic [CFG_DATA_W-1:0] val;
    char_t                 ch;
    bit                    last;
    bit                    pin;
    square_t               sq;
  } stim_row_t;

  // directed stimulus: reset defaults, zero width, char extremes, full square,
  // width shrunk mid-grid with the column counter already at the new width
  localparam int DIR_ROWS = 26;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_CELL, REG_ROW_WIDTH,     11'd0,    8'h00, 1'b1, 1'b1, '{11'd0, 10'd0, 10'd0}},
    '{ROW_CELL, REG_ROW_WIDTH,     11'd0,    8'hFF, 1'b1, 1'b1, '{11'd1, 10'd0, 10'd0}},
    '{ROW_CFG,  REG_ROW_WIDTH,     11'd0,    8'h00, 1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_OBSTACLE_CHAR, 11'h0FF,  8'h00, 1'b0, 1'b0, '0},
    '{ROW_CELL, REG_ROW_WIDTH,     11'd0,    8'h00, 1'b0, 1'b0, '0},
    '{ROW_CELL, REG_ROW_WIDTH,     11'd0,    8'hFF, 1'b0, 1'b0, '0},
    '{ROW_CELL, REG_ROW_WIDTH,     11'd0,    8'h41, 1'b1, 1'b1, '{11'd1, 10'd0, 10'd0}},
    '{ROW_CFG,  REG_ROW_WIDTH,     11'd3,    8'h00, 1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_OBSTACLE_CHAR, 11'h023,  8'h00, 1'b0, 1'b0, '0},
    '{ROW_CELL, REG_ROW_WIDTH,     11'd0,    8'h2E, 1'b0, 1'b0, '0},
    '{ROW_CELL, REG_ROW_WIDTH,     11'd0,    8'h7F, 1'b0, 1'b0, '0},
    '{ROW_CELL, REG_ROW_WIDTH,     11'd0,    8'h80, 1'b0, 1'b0, '0},
    '{ROW_CELL, REG_ROW_WIDTH,     11'd0,    8'h00, 1'b0, 1'b0, '0},
    '{ROW_CELL, REG_ROW_WIDTH,     11'd0,    8'hFF, 1'b0, 1'b0, '0},
    '{ROW_CELL, REG_ROW_WIDTH,     11'd0,    8'h55, 1'b0, 1'b0, '0},
    '{ROW_CELL, REG_ROW_WIDTH,     11'd0,    8'hAA, 1'b0, 1'b0, '0},
    '{ROW_CELL, REG_ROW_WIDTH,     11'd0,    8'h2E, 1'b0, 1'b0, '0},
    '{ROW_CELL, REG_ROW_WIDTH,     11'd0,    8'h01, 1'b1, 1'b1, '{11'd3, 10'd0, 10'd0}},
    '{ROW_CELL, REG_ROW_WIDTH,     11'd0,    8'h2E, 1'b0, 1'b0, '0},
    '{ROW_CELL, REG_ROW_WIDTH,     11'd0,    8'h23, 1'b0, 1'b0, '0},
    '{ROW_CELL, REG_ROW_WIDTH,     11'd0,    8'h2E, 1'b0, 1'b0, '0},
    '{ROW_CELL, REG_ROW_WIDTH,     11'd0,    8'h2E, 1'b0, 1'b0, '0},
    '{ROW_CELL, REG_ROW_WIDTH,     11'd0,    8'h2E, 1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_ROW_WIDTH,     11'd2,    8'h00, 1'b0, 1'b0, '0},
    '{ROW_CELL, REG_ROW_WIDTH,     11'd0,    8'h2E, 1'b0, 1'b0, '0},
    '{ROW_CELL, REG_ROW_WIDTH,     11'd0,    8'h2E, 1'b1, 1'b0, '0}
  };

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  cfg_idx_t              cfg_index = REG_ROW_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CHAR_W-1:0]     in_cell_char = '0;
  logic                  in_last_cell = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SCORE_W-1:0]    out_side_len;
  logic [TOP_W-1:0]      out_square_top;
  logic [LEFT_W-1:0]     out_square_left;

  largest_empty_square_scan_core #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cell_char    (in_cell_char),
    .in_last_cell    (in_last_cell),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_side_len    (out_side_len),
    .out_square_top  (out_square_top),
    .out_square_left (out_square_left)
  );

  // squares still owed by the block, and hand-typed squares for last cells
  square_t    pending_squares [$];
  pinned_sq_t pinned_squares [$];
  int         mismatch_count = 0;

  // idling controls for the sender and the receiver
  int sender_gap_pct = 0;
  int sink_stall_pct = 0;
  bit hold_req = 1'b0;

  // driver-side copy of the settings
  int    cur_width = 1;
  char_t cur_obst = '0;

  // predictor state
  logic [ROW_WIDTH_W-1:0] pred_width;
  char_t                  pred_obst;
  score_t                 row_scores [MAX_W];
  score_t                 left_s;
  score_t                 diag_s;
  logic [9:0]             col_cnt;
  logic [9:0]             row_cnt;
  score_t                 best_sz;
  logic [TOP_W-1:0]       best_t;
  logic [LEFT_W-1:0]      best_l;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  // score one accepted cell and queue the square it reports, if any
  task automatic scan_cell(input char_t ch, input logic last);
    int         eff_w;
    int         col;
    int         row;
    int         up_s;
    int         sc;
    int         m;
    square_t    sq;
    pinned_sq_t pq;
    eff_w = (pred_width == 0) ? 1 : (int'(pred_width) > MAX_W) ? MAX_W : int'(pred_width);
    col = int'(col_cnt);
    row = int'(row_cnt);
    // column counter left past a narrowed width wraps first
    if (col >= eff_w) begin
      col = 0;
      if (row < MAX_H - 1) row++;
    end
    up_s = int'(row_scores[col]);
    if (ch == pred_obst) begin
      sc = 0;
    end else if (row == 0 || col == 0) begin
      sc = 1;
    end else begin
      m = up_s;
      if (int'(left_s) < m) m = int'(left_s);
      if (int'(diag_s) < m) m = int'(diag_s);
      sc = m + 1;
    end
    sc = sc & 'h7FF;
    diag_s = score_t'(up_s);
    left_s = score_t'(sc);
    row_scores[col] = score_t'(sc);
    // only a strictly larger square replaces the best one
    if (sc > int'(best_sz)) begin
      best_sz = score_t'(sc);
      best_t  = (row + 1 >= sc) ? TOP_W'(row + 1 - sc) : '0;
      best_l  = (col + 1 >= sc) ? LEFT_W'(col + 1 - sc) : '0;
    end
    // advance, row index saturates at the height bound
    col++;
    if (col >= eff_w) begin
      col = 0;
      left_s = '0;
      diag_s = '0;
      if (row < MAX_H - 1) row++;
    end
    col_cnt = 10'(col);
    row_cnt = 10'(row);
    if (last) begin
      sq.side     = best_sz;
      sq.top_row  = best_t;
      sq.left_col = best_l;
      if (pinned_squares.size() != 0) begin
        pq = pinned_squares.pop_front();
        if (pq.pin) sq = pq.sq;
      end
      pending_squares.push_back(sq);
      left_s  = '0;
      diag_s  = '0;
      col_cnt = '0;
      row_cnt = '0;
      best_sz = '0;
      best_t  = '0;
      best_l  = '0;
    end
  endtask

  // monitor: check results, then track config writes and cell requests
  always @(posedge clk) begin
    square_t want;
    if (!rst_n) begin
      pred_width = 11'd1;
      pred_obst  = '0;
      foreach (row_scores[i]) row_scores[i] = '0;
      left_s  = '0;
      diag_s  = '0;
      col_cnt = '0;
      row_cnt = '0;
      best_sz = '0;
      best_t  = '0;
      best_l  = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_squares.size() == 0) begin
          $error("unexpected result: size %0d top %0d left %0d",
                 out_side_len, out_square_top, out_square_left);
          mismatch_count++;
        end else begin
          want = pending_squares.pop_front();
          if (out_side_len !== want.side) begin
            $error("side_len: expected %0d, got %0d", want.side, out_side_len);
            mismatch_count++;
          end
          if (out_square_top !== want.top_row) begin
            $error("square_top: expected %0d, got %0d", want.top_row, out_square_top);
            mismatch_count++;
          end
          if (out_square_left !== want.left_col) begin
            $error("square_left: expected %0d, got %0d", want.left_col, out_square_left);
            mismatch_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ROW_WIDTH:     pred_width = cfg_wdata;
          REG_OBSTACLE_CHAR: pred_obst  = cfg_wdata[CHAR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) scan_cell(in_cell_char, in_last_cell);
    end
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  // offer one cell request and wait for it to be taken
  task automatic send_cell(input char_t ch, input bit last, input bit pin, input square_t sq);
    pinned_sq_t pq;
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    if (last) begin
      pq.pin = pin;
      pq.sq  = sq;
      pinned_squares.push_back(pq);
    end
    in_valid     <= 1'b1;
    in_cell_char <= ch;
    in_last_cell <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop sending and let every owed square come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_squares.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // one register write, only called while the block is idle
  task automatic write_reg(input cfg_idx_t idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    if (idx == REG_OBSTACLE_CHAR) cur_obst = char_t'(val);
    else cur_width = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // one grid of random cells, blocked_pct percent of them obstacles
  task automatic send_grid(input int n_cells, input int blocked_pct);
    char_t ch;
    for (int i = 0; i < n_cells; i++) begin
      if ($urandom_range(0, 99) < blocked_pct) ch = cur_obst;
      else ch = char_t'($urandom_range(0, 255));
      send_cell(ch, i == n_cells - 1, 1'b0, '0);
    end
  endtask

  // random grids, settings changed now and then between grids
  task automatic random_grids(input int n_items);
    int sent;
    int w;
    int eff;
    int n;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 15))
          0:       w = 0;
          1:       w = MAX_W;
          2:       w = $urandom_range(MAX_W + 1, 2047);
          3:       w = 2047;
          default: w = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 8);
        endcase
        settle();
        write_reg(REG_ROW_WIDTH, w);
        write_reg(REG_OBSTACLE_CHAR, $urandom_range(0, 255));
      end
      eff = (cur_width == 0) ? 1 : (cur_width > MAX_W) ? MAX_W : cur_width;
      if (eff > 40) n = $urandom_range(1, 40);
      else n = eff * $urandom_range(1, 6);
      // some grids stop partway through a row
      if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
      if (n > n_items - sent) n = n_items - sent;
      send_grid(n, $urandom_range(0, 60));
      sent += n;
    end
  endtask

  // stimulus
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_gap_pct = 33;
    sink_stall_pct = 48;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        settle();
        write_reg(DIRECTED[i].idx, int'(DIRECTED[i].val));
      end else begin
        send_cell(DIRECTED[i].ch, DIRECTED[i].last, DIRECTED[i].pin, DIRECTED[i].sq);
      end
    end

    // width above the bound
    settle();
    write_reg(REG_ROW_WIDTH, 2047);
    write_reg(REG_OBSTACLE_CHAR, 8'h2A);
    send_grid(12, 5);

    // row counter saturates: one column of obstacles, then one open cell
    settle();
    write_reg(REG_ROW_WIDTH, 1);
    repeat (MAX_H + 1) send_cell(8'h2A, 1'b0, 1'b0, '0);
    send_cell(8'h2B, 1'b1, 1'b1, '{11'd1, 10'd1023, 10'd0});

    random_grids(12);

    // swap idling of the two sides, full width once
    settle();
    sender_gap_pct = 48;
    sink_stall_pct = 33;
    write_reg(REG_ROW_WIDTH, MAX_W);
    write_reg(REG_OBSTACLE_CHAR, 8'hFF);
    send_grid(8, 20);
    random_grids(12);

    // no idling; long receiver hold-off while single-cell grids pile up
    settle();
    sender_gap_pct = 0;
    sink_stall_pct = 0;
    write_reg(REG_ROW_WIDTH, 1);
    write_reg(REG_OBSTACLE_CHAR, 8'h00);
    hold_req = 1'b1;
    repeat (16) send_cell(char_t'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
    random_grids(12);

    settle();
    repeat (16) @(posedge clk);
    if (pending_squares.size() != 0) begin
      $error("%0d expected squares never arrived", pending_squares.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
